@@ rtl/spg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spg_pkg
// Shared types and constants of the step/direction pulse generator with
// homing: opcodes, controller modes, register indexes and word structs.
// ----------------------------------------------------------------------------
package spg_pkg;

    // default width of the position arithmetic
    localparam int POSITION_BITS_DEFAULT = 32;

    // elapsed counters and register widths
    localparam int COUNT_BITS    = 20;
    localparam int HALF_BITS     = 19;
    localparam int CFG_DATA_BITS = 20;
    localparam int CFG_IDX_BITS  = 1;
    localparam int LIMIT_BITS    = 31;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX         = '1;
    localparam logic [HALF_BITS-1:0]  HALF_PERIOD_RESET = 19'd500;
    localparam logic [COUNT_BITS-1:0] PAUSE_TICKS_RESET = 20'd500000;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_PERIOD = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PAUSE_TICKS = 1'd1;

    // command codes
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_ABS   = 2'd1,
        OP_REL   = 2'd2,
        OP_HOME  = 2'd3
    } op_t;

    // controller modes
    typedef enum logic [2:0] {
        MODE_IDLE      = 3'd0,
        MODE_WAIT_RISE = 3'd1,
        MODE_STEP_HIGH = 3'd2,
        MODE_HOMING    = 3'd3,
        MODE_PAUSE     = 3'd4
    } mode_t;

    // input word
    typedef struct packed {
        op_t                     operation;
        logic signed [31:0]      absolute_target;
        logic signed [31:0]      relative_offset;
        logic [LIMIT_BITS-1:0]   travel_limit;
        logic                    endstop_level;
    } item_t;

    // result word
    typedef struct packed {
        logic                    accepted;
        logic                    step_level;
        logic                    direction_level;
        logic                    enable_level;
        logic                    busy_res;
        logic                    is_calibrated;
        logic signed [31:0]      position;
    } result_t;

endpackage

@@ rtl/spg_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spg_in_stage
// Input register: holds one command or tick word until the controller
// core takes it.
// ----------------------------------------------------------------------------
module spg_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  spg_pkg::item_t item_in,
    input  logic           advance,
    output logic           item_valid,
    output spg_pkg::item_t item
);

    logic           valid_reg;
    logic           valid_next;
    spg_pkg::item_t item_reg;

    // room when empty or when the held word moves on this cycle
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_in;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ rtl/spg_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spg_core
// Controller state and single-pass update: move start, step timing,
// position counting, homing and settle pause, plus the result word.
// ----------------------------------------------------------------------------
module spg_core #(
    parameter int POSITION_BITS = spg_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               fire,
    input  spg_pkg::item_t                     item,
    input  logic                               cfg_valid,
    input  logic [spg_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [spg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output spg_pkg::result_t                   result
);

    localparam int P  = POSITION_BITS;
    localparam int CB = spg_pkg::COUNT_BITS;
    localparam int LB = spg_pkg::LIMIT_BITS;

    // state
    spg_pkg::mode_t              mode_reg, mode_next;
    logic [P-1:0]                pos_reg, pos_next;
    logic [P-1:0]                steps_reg, steps_next;
    logic [LB-1:0]               max_reg, max_next;
    logic                        cal_reg, cal_next;
    logic                        pulse_reg, pulse_next;
    logic                        dir_reg, dir_next;
    logic                        dis_reg, dis_next;
    logic [CB-1:0]               edge_reg, edge_next;
    logic [CB-1:0]               pause_reg, pause_next;
    logic [spg_pkg::HALF_BITS-1:0] half_reg;
    logic [CB-1:0]               pause_ticks_reg;

    // datapath
    spg_pkg::op_t                op;
    logic                        idle;
    logic [CB-1:0]               edge_inc;
    logic                        edge_due;
    logic [CB-1:0]               pause_inc;
    logic                        pause_done;
    logic [P-1:0]                steps_dec;
    logic [P-1:0]                pos_step;
    logic [LB-1:0]               clamp_t;
    logic [63:0]                 clamp_wide;
    logic [63:0]                 rel_wide;
    logic [P-1:0]                move_rel;
    logic                        move_nz;
    logic [P-1:0]                move_mag;
    logic                        accepted;
    logic [63:0]                 pos_wide;

    assign op   = item.operation;
    assign idle = (mode_reg == spg_pkg::MODE_IDLE);

    // saturating edge and pause counters
    assign edge_inc   = (edge_reg < spg_pkg::COUNT_MAX) ? edge_reg + CB'(1) : edge_reg;
    assign edge_due   = (edge_inc >= CB'(half_reg));
    assign pause_inc  = (pause_reg < spg_pkg::COUNT_MAX) ? pause_reg + CB'(1) : pause_reg;
    assign pause_done = (pause_inc >= pause_ticks_reg);

    // step counting and position update
    assign steps_dec = steps_reg - P'(1);
    assign pos_step  = dir_reg ? pos_reg + P'(1) : pos_reg - P'(1);

    // absolute target clamped to 0..max
    always_comb
    begin
        if (item.absolute_target < 0)
        begin
            clamp_t = '0;
        end
        else if (item.absolute_target > $signed({1'b0, max_reg}))
        begin
            clamp_t = max_reg;
        end
        else
        begin
            clamp_t = item.absolute_target[LB-1:0];
        end
    end

    // move distance, magnitude and direction
    assign clamp_wide = 64'(clamp_t);
    assign rel_wide   = 64'(item.relative_offset);
    assign move_rel   = (op == spg_pkg::OP_ABS) ? clamp_wide[P-1:0] - pos_reg
                                                : rel_wide[P-1:0];
    assign move_nz    = |move_rel;
    assign move_mag   = move_rel[P-1] ? -move_rel : move_rel;

    // command acceptance
    always_comb
    begin
        case (op)
            spg_pkg::OP_ABS:  accepted = cal_reg && idle;
            spg_pkg::OP_REL:  accepted = idle;
            spg_pkg::OP_HOME: accepted = idle;
            default:          accepted = 1'b0;
        endcase
    end

    // next mode
    always_comb
    begin
        mode_next = mode_reg;
        case (op)
            spg_pkg::OP_TICK:
            begin
                case (mode_reg)
                    spg_pkg::MODE_WAIT_RISE:
                    begin
                        if (edge_due)
                        begin
                            mode_next = spg_pkg::MODE_STEP_HIGH;
                        end
                    end
                    spg_pkg::MODE_STEP_HIGH:
                    begin
                        if (edge_due)
                        begin
                            mode_next = (steps_dec != '0) ? spg_pkg::MODE_WAIT_RISE
                                                         : spg_pkg::MODE_IDLE;
                        end
                    end
                    spg_pkg::MODE_HOMING:
                    begin
                        if (!item.endstop_level)
                        begin
                            mode_next = spg_pkg::MODE_PAUSE;
                        end
                    end
                    spg_pkg::MODE_PAUSE:
                    begin
                        if (pause_done)
                        begin
                            mode_next = spg_pkg::MODE_IDLE;
                        end
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
            spg_pkg::OP_ABS, spg_pkg::OP_REL:
            begin
                if (accepted && move_nz)
                begin
                    mode_next = spg_pkg::MODE_WAIT_RISE;
                end
            end
            spg_pkg::OP_HOME:
            begin
                if (accepted)
                begin
                    mode_next = spg_pkg::MODE_HOMING;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    // next datapath state
    always_comb
    begin
        pos_next   = pos_reg;
        steps_next = steps_reg;
        max_next   = max_reg;
        cal_next   = cal_reg;
        pulse_next = pulse_reg;
        dir_next   = dir_reg;
        dis_next   = dis_reg;
        edge_next  = edge_reg;
        pause_next = pause_reg;
        case (op)
            spg_pkg::OP_TICK:
            begin
                case (mode_reg)
                    spg_pkg::MODE_WAIT_RISE:
                    begin
                        edge_next = edge_due ? '0 : edge_inc;
                        if (edge_due)
                        begin
                            pulse_next = 1'b1;
                        end
                    end
                    spg_pkg::MODE_STEP_HIGH:
                    begin
                        edge_next = edge_due ? '0 : edge_inc;
                        if (edge_due)
                        begin
                            pulse_next = 1'b0;
                            steps_next = steps_dec;
                            pos_next   = pos_step;
                            if (steps_dec == '0)
                            begin
                                dis_next = 1'b1;
                            end
                        end
                    end
                    spg_pkg::MODE_HOMING:
                    begin
                        if (!item.endstop_level)
                        begin
                            pos_next   = '0;
                            cal_next   = 1'b1;
                            dis_next   = 1'b1;
                            pause_next = '0;
                        end
                        else
                        begin
                            edge_next = edge_due ? '0 : edge_inc;
                            if (edge_due)
                            begin
                                pulse_next = !pulse_reg;
                            end
                        end
                    end
                    spg_pkg::MODE_PAUSE:
                    begin
                        pause_next = pause_inc;
                    end
                    default:
                    begin
                        pos_next = pos_reg;
                    end
                endcase
            end
            spg_pkg::OP_ABS, spg_pkg::OP_REL:
            begin
                if (accepted && move_nz)
                begin
                    steps_next = move_mag;
                    dir_next   = !move_rel[P-1];
                    dis_next   = 1'b0;
                    edge_next  = '0;
                end
            end
            spg_pkg::OP_HOME:
            begin
                if (accepted)
                begin
                    max_next  = item.travel_limit;
                    dis_next  = 1'b0;
                    dir_next  = 1'b0;
                    edge_next = '0;
                    cal_next  = 1'b0;
                end
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= spg_pkg::MODE_IDLE;
            pos_reg   <= '0;
            steps_reg <= '0;
            max_reg   <= '0;
            cal_reg   <= 1'b0;
            pulse_reg <= 1'b0;
            dir_reg   <= 1'b0;
            dis_reg   <= 1'b1;
            edge_reg  <= '0;
            pause_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            steps_reg <= steps_next;
            max_reg   <= max_next;
            cal_reg   <= cal_next;
            pulse_reg <= pulse_next;
            dir_reg   <= dir_next;
            dis_reg   <= dis_next;
            edge_reg  <= edge_next;
            pause_reg <= pause_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg        <= spg_pkg::HALF_PERIOD_RESET;
            pause_ticks_reg <= spg_pkg::PAUSE_TICKS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                spg_pkg::CFG_HALF_PERIOD: half_reg        <= cfg_data[spg_pkg::HALF_BITS-1:0];
                spg_pkg::CFG_PAUSE_TICKS: pause_ticks_reg <= cfg_data;
                default:                  half_reg        <= half_reg;
            endcase
        end
    end

    // result word from the updated state
    assign pos_wide = 64'(pos_next);

    always_comb
    begin
        result.accepted        = accepted;
        result.step_level      = pulse_next;
        result.direction_level = dir_next;
        result.enable_level    = dis_next;
        result.busy_res        = (mode_next != spg_pkg::MODE_IDLE);
        result.is_calibrated   = cal_next;
        result.position        = pos_wide[31:0];
    end

endmodule

@@ rtl/spg_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spg_out_stage
// Result register: holds one result word until the consumer takes it and
// tells the core when the slot is free.
// ----------------------------------------------------------------------------
module spg_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  spg_pkg::result_t res_in,
    output logic             slot_free,
    output logic             out_valid,
    input  logic             out_ready,
    output spg_pkg::result_t res_out
);

    logic             valid_reg;
    logic             valid_next;
    spg_pkg::result_t res_reg;

    // slot is free when empty or being drained now
    assign slot_free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

@@ rtl/stepper_pulse_generator_with_homing.sv @@
`timescale 1ns / 1ps
// A word passes from the input register through the core to the result
// register; it waits while that register is full and not being drained.
// Throughput: one word per cycle but for that stall; one core pass per word.
// Reset: rst_n clears both stage valid flags and puts the controller idle,
// position zero, uncalibrated, driver disabled, registers at their defaults.
// ----------------------------------------------------------------------------
// stepper_pulse_generator_with_homing
// Step/direction stepper controller with homing, driven by microsecond
// ticks and move or homing commands.
// ----------------------------------------------------------------------------
module stepper_pulse_generator_with_homing #(
    parameter int POSITION_BITS = spg_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // command and tick words
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         operation,
    input  logic signed [31:0]                 absolute_target,
    input  logic signed [31:0]                 relative_offset,
    input  logic [30:0]                        travel_limit,
    input  logic                               endstop_level,
    // result words
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               accepted,
    output logic                               step_level,
    output logic                               direction_level,
    output logic                               enable_level,
    output logic                               busy_res,
    output logic                               is_calibrated,
    output logic signed [31:0]                 position,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [spg_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [spg_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    spg_pkg::item_t   item_in;
    spg_pkg::item_t   item;
    logic             item_valid;
    logic             slot_free;
    logic             core_fire;
    spg_pkg::result_t core_res;
    spg_pkg::result_t res_out;

    // pack input word
    always_comb
    begin
        item_in.operation       = spg_pkg::op_t'(operation);
        item_in.absolute_target = absolute_target;
        item_in.relative_offset = relative_offset;
        item_in.travel_limit    = travel_limit;
        item_in.endstop_level   = endstop_level;
    end

    assign core_fire = item_valid && slot_free;
    assign cfg_ready = 1'b1;

    spg_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .item_in    (item_in),
        .advance    (core_fire),
        .item_valid (item_valid),
        .item       (item)
    );

    spg_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (core_fire),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (core_res)
    );

    spg_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (core_fire),
        .res_in    (core_res),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_out   (res_out)
    );

    // unpack result word
    assign accepted        = res_out.accepted;
    assign step_level      = res_out.step_level;
    assign direction_level = res_out.direction_level;
    assign enable_level    = res_out.enable_level;
    assign busy_res        = res_out.busy_res;
    assign is_calibrated   = res_out.is_calibrated;
    assign position        = res_out.position;

    // an empty result register never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n) !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    // a core pass always lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n) core_fire |=> out_valid)
        else $error("core pass lost its result");

    // the driver is disabled whenever the controller is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !busy_res |-> enable_level)
        else $error("driver enabled while idle");

endmodule

@@ sim/spg_result_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spg_result_check
// Watches the command, result and register channels of the stepper pulse
// generator. Keeps its own copy of the axis state and registers, predicts the
// status word that each command or tick word should produce, and compares
// every result word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module spg_result_check (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic [1:0]                         operation,
    input  logic signed [31:0]                 absolute_target,
    input  logic signed [31:0]                 relative_offset,
    input  logic [30:0]                        travel_limit,
    input  logic                               endstop_level,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic                               accepted,
    input  logic                               step_level,
    input  logic                               direction_level,
    input  logic                               enable_level,
    input  logic                               busy_res,
    input  logic                               is_calibrated,
    input  logic signed [31:0]                 position,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [spg_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [spg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output int                                 mismatches,
    output int                                 outstanding
);

    // predicted axis state
    spg_pkg::mode_t                 axis_mode;
    logic [31:0]                    cur_pos;
    logic [31:0]                    steps_left;
    logic [spg_pkg::LIMIT_BITS-1:0] max_pos;
    logic                           calibrated;
    logic                           pulse;
    logic                           dir_up;
    logic                           drv_off;
    logic [spg_pkg::COUNT_BITS-1:0] edge_cnt;
    logic [spg_pkg::COUNT_BITS-1:0] pause_cnt;

    // register copies
    logic [spg_pkg::HALF_BITS-1:0]  half_period;
    logic [spg_pkg::COUNT_BITS-1:0] pause_ticks;

    // status words still to come out of the block
    spg_pkg::result_t predicted_status[$];

    // count one tick toward the next step edge
    function automatic logic edge_reached();
        if (edge_cnt != spg_pkg::COUNT_MAX)
            edge_cnt = edge_cnt + 1'b1;
        if (edge_cnt >= {1'b0, half_period})
        begin
            edge_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // start a move by a signed distance; a zero distance leaves the axis alone
    task automatic launch_move(input logic [31:0] move_dist);
        if (move_dist != 32'd0)
        begin
            if (move_dist[31])
            begin
                steps_left = 32'd0 - move_dist;
                dir_up     = 1'b0;
            end
            else
            begin
                steps_left = move_dist;
                dir_up     = 1'b1;
            end
            drv_off   = 1'b0;
            axis_mode = spg_pkg::MODE_WAIT_RISE;
            edge_cnt  = '0;
        end
    endtask

    // one microsecond tick
    task automatic tick_axis(input logic endstop);
        case (axis_mode)
            spg_pkg::MODE_WAIT_RISE:
                if (edge_reached())
                begin
                    pulse     = 1'b1;
                    axis_mode = spg_pkg::MODE_STEP_HIGH;
                end
            spg_pkg::MODE_STEP_HIGH:
                if (edge_reached())
                begin
                    pulse      = 1'b0;
                    steps_left = steps_left - 1'b1;
                    cur_pos    = dir_up ? cur_pos + 1'b1 : cur_pos - 1'b1;
                    if (steps_left != 32'd0)
                        axis_mode = spg_pkg::MODE_WAIT_RISE;
                    else
                    begin
                        axis_mode = spg_pkg::MODE_IDLE;
                        drv_off   = 1'b1;
                    end
                end
            spg_pkg::MODE_HOMING:
                if (!endstop)
                begin
                    cur_pos    = '0;
                    calibrated = 1'b1;
                    drv_off    = 1'b1;
                    axis_mode  = spg_pkg::MODE_PAUSE;
                    pause_cnt  = '0;
                end
                else if (edge_reached())
                    pulse = ~pulse;
            spg_pkg::MODE_PAUSE:
            begin
                if (pause_cnt != spg_pkg::COUNT_MAX)
                    pause_cnt = pause_cnt + 1'b1;
                if (pause_cnt >= pause_ticks)
                    axis_mode = spg_pkg::MODE_IDLE;
            end
            default: ;
        endcase
    endtask

    // apply one command or tick word and form the status word it yields
    task automatic advance_axis(input spg_pkg::op_t op, input logic signed [31:0] tgt,
                                input logic signed [31:0] off,
                                input logic [spg_pkg::LIMIT_BITS-1:0] lim,
                                input logic endstop, output spg_pkg::result_t status);
        logic              took;
        logic signed [31:0] goal;
        took = 1'b0;
        case (op)
            spg_pkg::OP_TICK:
                tick_axis(endstop);
            spg_pkg::OP_ABS:
                if (calibrated && axis_mode == spg_pkg::MODE_IDLE)
                begin
                    goal = tgt;
                    if (goal < 0)
                        goal = 0;
                    if (goal > $signed({1'b0, max_pos}))
                        goal = $signed({1'b0, max_pos});
                    launch_move(goal - cur_pos);
                    took = 1'b1;
                end
            spg_pkg::OP_REL:
                if (axis_mode == spg_pkg::MODE_IDLE)
                begin
                    launch_move(off);
                    took = 1'b1;
                end
            default:
                if (axis_mode == spg_pkg::MODE_IDLE)
                begin
                    max_pos    = lim;
                    drv_off    = 1'b0;
                    dir_up     = 1'b0;
                    axis_mode  = spg_pkg::MODE_HOMING;
                    edge_cnt   = '0;
                    calibrated = 1'b0;
                    took       = 1'b1;
                end
        endcase
        status.accepted        = took;
        status.step_level      = pulse;
        status.direction_level = dir_up;
        status.enable_level    = drv_off;
        status.busy_res        = (axis_mode != spg_pkg::MODE_IDLE);
        status.is_calibrated   = calibrated;
        status.position        = cur_pos;
    endtask

    // compare one field of a result word
    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want_v, got_v);
            mismatches++;
        end
    endtask

    // channel monitor
    always @(posedge clk or negedge rst_n)
    begin
        spg_pkg::result_t want;
        spg_pkg::result_t seen;
        if (!rst_n)
        begin
            axis_mode   = spg_pkg::MODE_IDLE;
            cur_pos     = '0;
            steps_left  = '0;
            max_pos     = '0;
            calibrated  = 1'b0;
            pulse       = 1'b0;
            dir_up      = 1'b0;
            drv_off     = 1'b1;
            edge_cnt    = '0;
            pause_cnt   = '0;
            half_period = spg_pkg::HALF_PERIOD_RESET;
            pause_ticks = spg_pkg::PAUSE_TICKS_RESET;
            predicted_status.delete();
            mismatches  = 0;
            outstanding <= 0;
        end
        else
        begin
            // result word against the oldest prediction
            if (out_valid && out_ready)
            begin
                seen = {accepted, step_level, direction_level, enable_level,
                        busy_res, is_calibrated, position};
                if (predicted_status.size() == 0)
                begin
                    $error("result word with no prediction waiting");
                    mismatches++;
                end
                else
                begin
                    want = predicted_status.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(seen.accepted));
                    check_field("step_level", 32'(want.step_level),
                                32'(seen.step_level));
                    check_field("direction_level", 32'(want.direction_level),
                                32'(seen.direction_level));
                    check_field("enable_level", 32'(want.enable_level),
                                32'(seen.enable_level));
                    check_field("busy_res", 32'(want.busy_res), 32'(seen.busy_res));
                    check_field("is_calibrated", 32'(want.is_calibrated),
                                32'(seen.is_calibrated));
                    check_field("position", want.position, seen.position);
                end
            end

            // register writes
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == spg_pkg::CFG_HALF_PERIOD)
                    half_period = cfg_data[spg_pkg::HALF_BITS-1:0];
                else if (cfg_index == spg_pkg::CFG_PAUSE_TICKS)
                    pause_ticks = cfg_data;
            end

            // command or tick word
            if (in_valid && in_ready)
            begin
                advance_axis(spg_pkg::op_t'(operation), absolute_target,
                             relative_offset, travel_limit, endstop_level, want);
                predicted_status.push_back(want);
            end

            outstanding <= predicted_status.size();
        end
    end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top of the stepper pulse generator bench. Drives command and tick words,
// register writes and result back-pressure; a directed opening covers
// refused commands, zero moves, position wrap, homing and register extremes,
// then random move and homing sequences run under several register settings.
// ----------------------------------------------------------------------------
module tb;

    localparam int HOLD_CYCLES   = 100;
    localparam int PHASE_ITEMS   = 200;
    localparam int SETTLE_CYCLES = 10;
    localparam int LIMIT_NS      = 2_000_000;

    // register write data
    typedef logic [spg_pkg::CFG_DATA_BITS-1:0] cfg_word_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic [1:0]                         operation = spg_pkg::OP_TICK;
    logic signed [31:0]                 absolute_target = '0;
    logic signed [31:0]                 relative_offset = '0;
    logic [30:0]                        travel_limit = '0;
    logic                               endstop_level = 1'b1;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic                               accepted;
    logic                               step_level;
    logic                               direction_level;
    logic                               enable_level;
    logic                               busy_res;
    logic                               is_calibrated;
    logic signed [31:0]                 position;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [spg_pkg::CFG_IDX_BITS-1:0]   cfg_index = spg_pkg::CFG_HALF_PERIOD;
    logic [spg_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;
    int                                 mismatches;
    int                                 outstanding;

    // sequencing flags for the result side
    bit                        steady = 1'b0;
    bit                        hold_req = 1'b0;

    stepper_pulse_generator_with_homing dut (
        .clk, .rst_n,
        .in_valid, .in_ready, .operation, .absolute_target, .relative_offset,
        .travel_limit, .endstop_level,
        .out_valid, .out_ready, .accepted, .step_level, .direction_level,
        .enable_level, .busy_res, .is_calibrated, .position,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    spg_result_check u_check (
        .clk, .rst_n,
        .in_valid, .in_ready, .operation, .absolute_target, .relative_offset,
        .travel_limit, .endstop_level,
        .out_valid, .out_ready, .accepted, .step_level, .direction_level,
        .enable_level, .busy_res, .is_calibrated, .position,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .mismatches, .outstanding
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(LIMIT_NS);
        $display("FAIL stepper_pulse_generator_with_homing");
        $finish;
    end

    // result side back-pressure
    initial
    begin : sink
        int span;
        bit held;
        held = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            span = $urandom_range(1, 14);
            if (hold_req && !held)
            begin
                // long hold-off so the block fills and stalls its input
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (steady)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else if ($urandom_range(0, 2) != 0)
            begin
                out_ready <= 1'b1;
                repeat (span) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b0;
                repeat (span) @(posedge clk);
            end
        end
    end

    // offer one word and wait until it is taken
    task automatic push_word(input spg_pkg::op_t op, input logic [31:0] tgt,
                             input logic [31:0] off, input logic [30:0] lim,
                             input logic endstop);
        if (!steady && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        operation       <= op;
        absolute_target <= tgt;
        relative_offset <= off;
        travel_limit    <= lim;
        endstop_level   <= endstop;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // tick word; the command fields ride along with random content
    task automatic send_tick(input logic endstop);
        push_word(spg_pkg::OP_TICK, $urandom, $urandom, 31'($urandom), endstop);
    endtask

    // stop offering and wait for every predicted word to come out
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // register write once the block has drained
    task automatic set_reg(input logic [spg_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [spg_pkg::CFG_DATA_BITS-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // random move and homing sequences under one register setting
    task automatic run_phase(input int half, input int pause, input int n_items,
                             input bit with_hold);
        int sent;
        int run_len;
        int pick;
        int offset;
        logic [31:0] tgt;
        set_reg(spg_pkg::CFG_HALF_PERIOD, cfg_word_t'(half));
        set_reg(spg_pkg::CFG_PAUSE_TICKS, cfg_word_t'(pause));
        if (with_hold)
            hold_req <= 1'b1;
        sent = 0;
        while (sent < n_items)
        begin
            pick   = $urandom_range(0, 99);
            offset = $urandom_range(0, 16) - 8;
            tgt    = (pick % 2 == 0) ? $urandom : $urandom_range(0, 40) - 8;
            // one command opens the sequence
            if (pick < 15)
                push_word(spg_pkg::OP_HOME, $urandom, $urandom,
                          31'($urandom_range(0, 16)), 1'($urandom_range(0, 1)));
            else if (pick < 55)
                push_word(spg_pkg::OP_ABS, tgt, $urandom, 31'($urandom),
                          1'($urandom_range(0, 1)));
            else
                push_word(spg_pkg::OP_REL, $urandom, offset, 31'($urandom),
                          1'($urandom_range(0, 1)));
            // then a run of ticks, now and then broken by a stray command
            run_len = $urandom_range(1, 30);
            repeat (run_len)
            begin
                if ($urandom_range(0, 9) == 0)
                    push_word(spg_pkg::OP_REL, $urandom, $urandom_range(0, 6) - 3,
                              31'($urandom), 1'($urandom_range(0, 1)));
                else
                    send_tick($urandom_range(0, 5) != 0);
            end
            sent += run_len + 1;
        end
    endtask

    // stimulus and verdict
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: uncalibrated absolute move, zero move
        push_word(spg_pkg::OP_ABS, 32'd5, 32'd0, 31'd0, 1'b1);
        push_word(spg_pkg::OP_REL, 32'd0, 32'd0, 31'd0, 1'b1);
        send_tick(1'b1);

        // edge on every tick, zero pause
        set_reg(spg_pkg::CFG_HALF_PERIOD, 20'd0);
        set_reg(spg_pkg::CFG_PAUSE_TICKS, 20'd0);

        // one step down wraps the position; commands while busy are refused
        push_word(spg_pkg::OP_REL, 32'd0, 32'hFFFF_FFFF, 31'd0, 1'b1);
        push_word(spg_pkg::OP_REL, 32'd0, 32'h7FFF_FFFF, 31'd0, 1'b1);
        push_word(spg_pkg::OP_REL, 32'd0, 32'h8000_0000, 31'd0, 1'b1);
        push_word(spg_pkg::OP_HOME, 32'd0, 32'd0, 31'h7FFF_FFFF, 1'b1);
        repeat (2) send_tick(1'b1);

        // homing with the widest travel limit, pulses then endstop hit
        push_word(spg_pkg::OP_HOME, 32'd0, 32'd0, 31'h7FFF_FFFF, 1'b1);
        repeat (2) send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);

        // clamp at zero gives a zero move, then a short absolute move
        push_word(spg_pkg::OP_ABS, 32'h8000_0000, 32'd0, 31'd0, 1'b1);
        push_word(spg_pkg::OP_ABS, 32'd2, 32'd0, 31'd0, 1'b1);
        repeat (4) send_tick(1'b1);

        // home with a small limit and clamp the largest target to it
        push_word(spg_pkg::OP_HOME, 32'd0, 32'd0, 31'd3, 1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        push_word(spg_pkg::OP_ABS, 32'h7FFF_FFFF, 32'd0, 31'd0, 1'b1);
        repeat (6) send_tick(1'b1);

        // slow step rate and long pause, released by later writes
        set_reg(spg_pkg::CFG_HALF_PERIOD, 20'd500000);
        set_reg(spg_pkg::CFG_PAUSE_TICKS, 20'd1000000);
        push_word(spg_pkg::OP_REL, 32'd0, 32'd1, 31'd0, 1'b1);
        repeat (3) send_tick(1'b1);
        set_reg(spg_pkg::CFG_HALF_PERIOD, 20'd1);
        repeat (3) send_tick(1'b1);
        push_word(spg_pkg::OP_HOME, 32'd0, 32'd0, 31'd16, 1'b1);
        repeat (3) send_tick(1'b0);
        set_reg(spg_pkg::CFG_PAUSE_TICKS, 20'd1);
        send_tick(1'b1);

        // random sequences; the last phase runs without idling
        run_phase(0, 1, PHASE_ITEMS, 1'b0);
        run_phase(1, 4, PHASE_ITEMS, 1'b1);
        run_phase(3, 12, PHASE_ITEMS, 1'b0);
        steady <= 1'b1;
        run_phase(2, 2, PHASE_ITEMS, 1'b0);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS stepper_pulse_generator_with_homing");
        else
            $display("FAIL stepper_pulse_generator_with_homing");
        $finish;
    end

endmodule
